// File: rtl/core/tcce_pkg.sv
// Shared constants and widths for the text console character engine.
package tcce_pkg;

   localparam int DEF_COLS      = 80;
   localparam int DEF_ROWS      = 25;
   localparam int DEF_TAB_WIDTH = 8;

   localparam int POS_W  = 11;
   localparam int CELL_W = 16;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [0:0] REG_TEXT_ATTRIBUTE = 1'b0;

   localparam logic REQ_PUT  = 1'b0;
   localparam logic REQ_READ = 1'b1;

   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

   localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_ESC      = 8'h1B;
   localparam logic [CHAR_W-1:0] CH_BLANK    = 8'h20;
   localparam logic [CHAR_W-1:0] CH_LBRACKET = 8'h5B;
   localparam logic [CHAR_W-1:0] CH_LEFT     = 8'h44;
   localparam logic [CHAR_W-1:0] CH_RIGHT    = 8'h43;

   localparam logic [CELL_W-1:0] BLANK_RESET = {ATTR_RESET, CH_BLANK};

endpackage

// File: rtl/core/tcce_if.sv
// Request and response channel interfaces of the text console engine.
interface tcce_req_if import tcce_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [CHAR_W-1:0] char_code;
   logic [POS_W-1:0]  cell_index;

   modport source (output valid, req_type, char_code, cell_index, input ready);
   modport sink   (input valid, req_type, char_code, cell_index, output ready);
endinterface

interface tcce_rsp_if import tcce_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [POS_W-1:0]  cursor_pos;
   logic [CELL_W-1:0] cell_data;
   logic              escape_pending;

   modport source (output valid, cursor_pos, cell_data, escape_pending, input ready);
   modport sink   (input valid, cursor_pos, cell_data, escape_pending, output ready);
endinterface

// File: rtl/core/tcce_ram.sv
// Generic single-write, single-read RAM with registered, enabled read.
module tcce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: rtl/core/text_console_char_engine_top.sv
// Text console engine: screen RAM, cursor, escape decoding and scrolling.
//
// Usage:
//  req_ch carries one item per handshake: a put (req_type 0) feeds char_code
//  to the console, a read (req_type 1) fetches the screen cell at cell_index.
//  rsp_ch returns exactly one item per request: the cursor position after the
//  request, the cell read (zero for puts) and the escape-pending flag.
//  The APB port holds text_attribute at address 0; write it only while idle.
//  The result of a request passes through the S_DONE state into the output
//  register; a put that scrolls first passes through S_COPY, copying rows
//  up through the single RAM read port, and S_BLANK, blanking the last row.
//  A new request is taken only in S_IDLE, after the last one's result has
//  been registered; the screen RAM has a single write port shared by
//  prints, scrolls and clearing. After reset the screen RAM is cleared one
//  cell per cycle; requests are held off meanwhile, APB writes not.
//  A stalled receiver keeps the result in the output register; the next
//  request is still taken and worked on, and its result waits behind it.
module text_console_char_engine_top import tcce_pkg::*; #(
   parameter int COLS      = DEF_COLS,
   parameter int ROWS      = DEF_ROWS,
   parameter int TAB_WIDTH = DEF_TAB_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   tcce_req_if.sink              req_ch,
   tcce_rsp_if.source            rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int NCELLS = COLS * ROWS;
   localparam int AW     = $clog2(NCELLS);
   localparam int COL_W  = $clog2(COLS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int ROWX_W = ROW_W + 1;
   localparam int CNX_W  = $clog2(COLS + TAB_WIDTH);
   localparam int MOD_W  = $clog2(TAB_WIDTH);

   typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_COPY, S_BLANK, S_DONE} state_type;
   typedef enum logic [1:0] {ESC_NONE, ESC_SEEN, ESC_BRACKET} esc_type;

   state_type         state_ff, state_in;
   esc_type           esc_ff, esc_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [MOD_W-1:0]  mod_ff, mod_in;
   logic [AW-1:0]     cnt_ff, cnt_in;
   logic              rd_hit_ff, rd_hit_in;
   logic [ATTR_W-1:0] attr_ff, attr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic [CELL_W-1:0] rsp_cell_ff, rsp_cell_in;
   logic              rsp_esc_ff, rsp_esc_in;

   logic              ram_we, ram_re;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   logic [CELL_W-1:0] ram_wdata, ram_rdata;

   logic              accept;
   logic [AW-1:0]     pos_cur;

   // next cursor for a put
   logic [CNX_W-1:0]  put_col;
   logic [ROWX_W-1:0] put_row;
   logic [MOD_W-1:0]  put_mod;
   esc_type           put_esc;
   logic              put_print;
   logic              put_scroll;
   logic [MOD_W-1:0]  mod_inc, mod_dec;

   tcce_ram #(.WIDTH(CELL_W), .DEPTH(NCELLS)) u_screen (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign pos_cur = AW'(row_ff) * AW'(COLS) + AW'(col_ff);
   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.cursor_pos     = rsp_pos_ff;
   assign rsp_ch.cell_data      = rsp_cell_ff;
   assign rsp_ch.escape_pending = rsp_esc_ff;

   assign pready = 1'b1;
   assign prdata = (paddr[CSR_ADDR_W-1:2] == REG_TEXT_ATTRIBUTE) ?
                   CSR_DATA_W'(attr_ff) : '0;

   assign mod_inc = (mod_ff == MOD_W'(TAB_WIDTH - 1)) ? '0 : mod_ff + 1'b1;
   assign mod_dec = (mod_ff == '0) ? MOD_W'(TAB_WIDTH - 1) : mod_ff - 1'b1;

   always_comb begin
      put_col    = CNX_W'(col_ff);
      put_row    = ROWX_W'(row_ff);
      put_mod    = mod_ff;
      put_esc    = esc_ff;
      put_print  = 1'b0;
      put_scroll = 1'b0;
      unique case (esc_ff)
         ESC_SEEN: begin
            put_esc = (req_ch.char_code == CH_LBRACKET) ? ESC_BRACKET : ESC_NONE;
         end
         ESC_BRACKET: begin
            put_esc = ESC_NONE;
            if (req_ch.char_code == CH_LEFT && col_ff != '0) begin
               put_col = put_col - 1'b1;
               put_mod = mod_dec;
            end else if (req_ch.char_code == CH_RIGHT &&
                         col_ff != COL_W'(COLS - 1)) begin
               put_col = put_col + 1'b1;
               put_mod = mod_inc;
            end
         end
         ESC_NONE: begin
            priority if (req_ch.char_code == CH_ESC) begin
               put_esc = ESC_SEEN;
            end else if (req_ch.char_code == CH_BS) begin
               if (col_ff != '0) begin
                  put_col = put_col - 1'b1;
                  put_mod = mod_dec;
               end
            end else if (req_ch.char_code == CH_TAB) begin
               put_col = put_col + CNX_W'(TAB_WIDTH) - CNX_W'(mod_ff);
               put_mod = '0;
            end else if (req_ch.char_code == CH_CR) begin
               put_col = '0;
               put_mod = '0;
            end else if (req_ch.char_code == CH_LF) begin
               put_col = '0;
               put_mod = '0;
               put_row = put_row + 1'b1;
            end else if (req_ch.char_code >= CH_BLANK) begin
               put_print = 1'b1;
               put_col   = put_col + 1'b1;
               put_mod   = mod_inc;
            end else begin
               put_col = CNX_W'(col_ff);
            end
         end
         default: begin
            put_esc = ESC_NONE;
         end
      endcase
      // wrap past the last column, then scroll past the last row
      if (put_col >= CNX_W'(COLS)) begin
         put_col = '0;
         put_mod = '0;
         put_row = put_row + 1'b1;
      end
      if (put_row >= ROWX_W'(ROWS)) begin
         put_row    = ROWX_W'(ROWS - 1);
         put_scroll = 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      esc_in       = esc_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      mod_in       = mod_ff;
      cnt_in       = cnt_ff;
      rd_hit_in    = rd_hit_ff;
      attr_in      = attr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_cell_in  = rsp_cell_ff;
      rsp_esc_in   = rsp_esc_ff;
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = '0;
      ram_re       = 1'b0;
      ram_raddr    = '0;

      if (psel && penable && pwrite && paddr[CSR_ADDR_W-1:2] == REG_TEXT_ATTRIBUTE) begin
         attr_in = pwdata[ATTR_W-1:0];
      end

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = cnt_ff;
            ram_wdata = BLANK_RESET;
            if (cnt_ff == AW'(NCELLS - 1)) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (req_ch.req_type == REQ_READ) begin
                  ram_re    = 1'b1;
                  ram_raddr = AW'(req_ch.cell_index);
                  rd_hit_in = (int'(req_ch.cell_index) < NCELLS);
                  state_in  = S_DONE;
               end else begin
                  rd_hit_in = 1'b0;
                  col_in    = COL_W'(put_col);
                  row_in    = ROW_W'(put_row);
                  mod_in    = put_mod;
                  esc_in    = put_esc;
                  cnt_in    = '0;
                  ram_we    = put_print;
                  ram_waddr = pos_cur;
                  ram_wdata = {attr_ff, req_ch.char_code};
                  state_in  = put_scroll ? S_COPY : S_DONE;
               end
            end
         end
         S_COPY: begin
            // read one row ahead, write back what the last cycle fetched
            if (cnt_ff != AW'(NCELLS - COLS)) begin
               ram_re    = 1'b1;
               ram_raddr = cnt_ff + AW'(COLS);
               cnt_in    = cnt_ff + 1'b1;
            end else begin
               state_in = S_BLANK;
            end
            if (cnt_ff != '0) begin
               ram_we    = 1'b1;
               ram_waddr = cnt_ff - 1'b1;
               ram_wdata = ram_rdata;
            end
         end
         S_BLANK: begin
            ram_we    = 1'b1;
            ram_waddr = cnt_ff;
            ram_wdata = {attr_ff, CH_BLANK};
            if (cnt_ff == AW'(NCELLS - 1)) begin
               cnt_in   = '0;
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = POS_W'(pos_cur);
               rsp_cell_in  = rd_hit_ff ? ram_rdata : '0;
               rsp_esc_in   = (esc_ff != ESC_NONE);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         esc_ff       <= ESC_NONE;
         col_ff       <= '0;
         row_ff       <= '0;
         mod_ff       <= '0;
         cnt_ff       <= '0;
         rd_hit_ff    <= 1'b0;
         attr_ff      <= ATTR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         esc_ff       <= esc_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         mod_ff       <= mod_in;
         cnt_ff       <= cnt_in;
         rd_hit_ff    <= rd_hit_in;
         attr_ff      <= attr_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_pos_ff   <= rsp_pos_in;
         rsp_cell_ff  <= rsp_cell_in;
         rsp_esc_ff   <= rsp_esc_in;
      end
   end

   a_cursor_bounds: assert property (@(posedge clock) disable iff (reset)
      int'(col_ff) < COLS && int'(row_ff) < ROWS)
      else $error("cursor outside the screen");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside the completion state");

   a_scroll_last_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BLANK) |-> (row_ff == ROW_W'(ROWS - 1)))
      else $error("blanking a row while the cursor is off the last row");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the text console engine: directed table, then random request sequences.
module tb_top;
   import tcce_pkg::*;

   localparam int NCELLS      = DEF_COLS * DEF_ROWS;
   localparam int PHASES      = 5;
   localparam int PHASE_ITEMS = 400;
   localparam int TAIL_CYCLES = 40;
   localparam int HOLD_AFTER  = 600;
   localparam int HOLD_CYCLES = 300;
   localparam int SHOW_LIMIT  = 10;
   localparam int NUM_DIR     = 25;

   localparam logic [CSR_ADDR_W-1:0] ATTR_ADDR = CSR_ADDR_W'(4 * REG_TEXT_ATTRIBUTE);

   typedef enum logic [1:0] {ESC_NONE, ESC_OPEN, ESC_CSI} esc_stage_type;

   typedef struct packed {
      logic              kind;
      logic [CHAR_W-1:0] ch;
      logic [POS_W-1:0]  idx;
   } console_req_type;

   typedef struct packed {
      logic [POS_W-1:0]  pos;
      logic [CELL_W-1:0] data;
      logic              pend;
   } console_rsp_type;

   typedef struct packed {
      console_req_type rq;
      logic            typed;
      console_rsp_type rsp;
   } dir_row_type;

   // kind, byte, index, typed, cursor, cell, escape pending
   localparam dir_row_type DIR_TAB [NUM_DIR] = '{
      {REQ_READ, 8'h00,       11'd0,    1'b1, 11'd0,  BLANK_RESET, 1'b0},
      {REQ_READ, 8'h00,       11'd2047, 1'b1, 11'd0,  16'h0000,    1'b0},
      {REQ_READ, 8'hFF,       11'd1999, 1'b1, 11'd0,  BLANK_RESET, 1'b0},
      {REQ_PUT,  CH_BS,       11'd0,    1'b1, 11'd0,  16'h0000,    1'b0},
      {REQ_PUT,  CH_ESC,      11'd2047, 1'b1, 11'd0,  16'h0000,    1'b1},
      {REQ_PUT,  CH_LBRACKET, 11'd0,    1'b1, 11'd0,  16'h0000,    1'b1},
      {REQ_PUT,  CH_LEFT,     11'd0,    1'b1, 11'd0,  16'h0000,    1'b0},
      {REQ_PUT,  8'h00,       11'd0,    1'b1, 11'd0,  16'h0000,    1'b0},
      {REQ_PUT,  8'hFF,       11'd0,    1'b1, 11'd1,  16'h0000,    1'b0},
      {REQ_READ, 8'h00,       11'd0,    1'b1, 11'd1,  16'h0FFF,    1'b0},
      {REQ_PUT,  CH_BLANK,    11'd0,    1'b1, 11'd2,  16'h0000,    1'b0},
      {REQ_PUT,  CH_BS,       11'd0,    1'b1, 11'd1,  16'h0000,    1'b0},
      {REQ_PUT,  CH_TAB,      11'd0,    1'b1, 11'd8,  16'h0000,    1'b0},
      {REQ_PUT,  CH_ESC,      11'd0,    1'b1, 11'd8,  16'h0000,    1'b1},
      {REQ_PUT,  8'h5A,       11'd0,    1'b1, 11'd8,  16'h0000,    1'b0},
      {REQ_PUT,  CH_ESC,      11'd0,    1'b1, 11'd8,  16'h0000,    1'b1},
      {REQ_PUT,  CH_LBRACKET, 11'd0,    1'b1, 11'd8,  16'h0000,    1'b1},
      {REQ_PUT,  8'h5A,       11'd0,    1'b1, 11'd8,  16'h0000,    1'b0},
      {REQ_PUT,  CH_ESC,      11'd0,    1'b0, 11'd0,  16'h0000,    1'b0},
      {REQ_PUT,  CH_LBRACKET, 11'd0,    1'b0, 11'd0,  16'h0000,    1'b0},
      {REQ_PUT,  CH_RIGHT,    11'd0,    1'b1, 11'd9,  16'h0000,    1'b0},
      {REQ_READ, 8'h00,       11'd1,    1'b0, 11'd0,  16'h0000,    1'b0},
      {REQ_PUT,  CH_CR,       11'd0,    1'b1, 11'd0,  16'h0000,    1'b0},
      {REQ_PUT,  CH_LF,       11'd0,    1'b1, 11'd80, 16'h0000,    1'b0},
      {REQ_PUT,  8'h1F,       11'd0,    1'b1, 11'd80, 16'h0000,    1'b0}
   };

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   tcce_req_if req_ch ();
   tcce_rsp_if rsp_ch ();

   text_console_char_engine_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Shadow of the console: screen, cursor, escape stage, attribute
   logic [CELL_W-1:0] screen_copy [NCELLS];
   logic [6:0]        cur_col;
   logic [4:0]        cur_row;
   esc_stage_type     esc_state;
   logic [ATTR_W-1:0] attr_shadow;

   console_rsp_type result_q [$];
   int              items_sent   = 0;
   int              results_seen = 0;
   int              fail_count   = 0;
   bit              idle_on      = 1'b1;
   logic            hold_rsp;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic logic [POS_W-1:0] cursor_index();
      return POS_W'(cur_row) * POS_W'(DEF_COLS) + POS_W'(cur_col);
   endfunction

   function automatic logic [CHAR_W-1:0] any_printable();
      return CHAR_W'($urandom_range(CH_BLANK, 255));
   endfunction

   function automatic void report_fail(input string what);
      fail_count++;
      if (fail_count <= SHOW_LIMIT) $display("%s", what);
   endfunction

   function automatic void feed_byte(input logic [CHAR_W-1:0] c);
      if (esc_state == ESC_OPEN) begin
         esc_state = (c == CH_LBRACKET) ? ESC_CSI : ESC_NONE;
         return;
      end
      if (esc_state == ESC_CSI) begin
         if (c == CH_LEFT && cur_col != 0) cur_col--;
         else if (c == CH_RIGHT && cur_col < DEF_COLS - 1) cur_col++;
         esc_state = ESC_NONE;
         return;
      end
      case (c)
         CH_ESC: begin
            esc_state = ESC_OPEN;
            return;
         end
         CH_BS: if (cur_col != 0) cur_col--;
         CH_TAB: cur_col = cur_col + 7'(DEF_TAB_WIDTH) - cur_col % 7'(DEF_TAB_WIDTH);
         CH_CR: cur_col = '0;
         CH_LF: begin
            cur_col = '0;
            cur_row++;
         end
         default: begin
            if (c >= CH_BLANK) begin
               screen_copy[cursor_index()] = {attr_shadow, c};
               cur_col++;
            end
         end
      endcase
      if (cur_col >= DEF_COLS) begin
         cur_col = '0;
         cur_row++;
      end
      // scroll up one row and blank the last with the current attribute
      if (cur_row >= DEF_ROWS) begin
         for (int i = 0; i < NCELLS - DEF_COLS; i++) screen_copy[i] = screen_copy[i + DEF_COLS];
         for (int i = NCELLS - DEF_COLS; i < NCELLS; i++) screen_copy[i] = {attr_shadow, CH_BLANK};
         cur_row = 5'(DEF_ROWS - 1);
      end
   endfunction

   function automatic console_rsp_type console_apply(input console_req_type rq);
      console_rsp_type r;
      r.data = '0;
      if (rq.kind == REQ_READ) begin
         if (rq.idx < NCELLS) r.data = screen_copy[rq.idx];
      end else begin
         feed_byte(rq.ch);
      end
      r.pos  = cursor_index();
      r.pend = (esc_state != ESC_NONE);
      return r;
   endfunction

   // Offer one item and hold it until taken; valid stays high for the next one
   task automatic send_req(input console_req_type rq, input logic typed,
                           input console_rsp_type want);
      console_rsp_type pred;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.req_type   <= rq.kind;
      req_ch.char_code  <= rq.ch;
      req_ch.cell_index <= rq.idx;
      do @(posedge clock); while (!req_ch.ready);
      pred = console_apply(rq);
      result_q.push_back(typed ? want : pred);
      items_sent++;
   endtask

   task automatic put_byte(input logic [CHAR_W-1:0] c);
      send_req(console_req_type'{REQ_PUT, c, POS_W'($urandom_range(0, 2**POS_W - 1))},
               1'b0, '0);
   endtask

   task automatic read_cell(input logic [POS_W-1:0] idx);
      send_req(console_req_type'{REQ_READ, CHAR_W'($urandom_range(0, 255)), idx}, 1'b0, '0);
   endtask

   task automatic wait_drained();
      while (result_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_attribute(input logic [ATTR_W-1:0] val);
      logic [CSR_DATA_W-1:0] rd;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ATTR_ADDR;
      pwdata  <= CSR_DATA_W'(val);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      attr_shadow = val;
      // read back straight after the write
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      rd = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (rd[ATTR_W-1:0] !== val)
         report_fail($sformatf("attribute read-back: expected %h, actual %h", val, rd));
   endtask

   // One random sequence of items, mostly well formed
   task automatic feed_random_sequence();
      int               sel;
      int               n;
      logic [POS_W-1:0] near;
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
         put_byte(any_printable());
      end else if (sel < 45) begin
         n = $urandom_range(3, 10);
         repeat (n) put_byte(any_printable());
      end else if (sel < 53) begin
         read_cell(POS_W'($urandom_range(0, NCELLS - 1)));
      end else if (sel < 61) begin
         near = cursor_index();
         read_cell(near == 0 ? near : near - 1'b1);
      end else if (sel < 64) begin
         read_cell(POS_W'($urandom_range(NCELLS, 2**POS_W - 1)));
      end else if (sel < 74) begin
         put_byte(CH_ESC);
         put_byte(CH_LBRACKET);
         put_byte($urandom_range(0, 1) ? CH_LEFT : CH_RIGHT);
      end else if (sel < 79) begin
         put_byte(CH_ESC);
         if ($urandom_range(0, 1)) put_byte(CH_LBRACKET);
         put_byte(CHAR_W'($urandom_range(0, 255)));
      end else if (sel < 86) begin
         case ($urandom_range(0, 2))
            0: put_byte(CH_TAB);
            1: put_byte(CH_BS);
            default: put_byte(CH_CR);
         endcase
      end else if (sel < 88) begin
         put_byte(CH_LF);
      end else if (sel < 96) begin
         put_byte(CHAR_W'($urandom_range(0, 255)));
      end else begin
         // run to the last column, try to move right past it, then wrap
         while (cur_col < DEF_COLS - DEF_TAB_WIDTH) put_byte(CH_TAB);
         while (cur_col < DEF_COLS - 1) put_byte(any_printable());
         put_byte(CH_ESC);
         put_byte(CH_LBRACKET);
         put_byte(CH_RIGHT);
         put_byte(any_printable());
      end
   endtask

   // Result side: check each item, idle in short bursts, honour the long hold
   initial begin
      console_rsp_type got;
      console_rsp_type want;
      int              rsp_gap;
      logic            nxt;
      rsp_gap = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            got = '{rsp_ch.cursor_pos, rsp_ch.cell_data, rsp_ch.escape_pending};
            if (result_q.size() == 0) begin
               report_fail($sformatf("unexpected result: cursor %0d cell %h esc %b",
                                     got.pos, got.data, got.pend));
            end else begin
               want = result_q.pop_front();
               if (got.pos !== want.pos || got.data !== want.data || got.pend !== want.pend)
                  report_fail($sformatf(
                     "result %0d: cursor %0d/%0d cell %h/%h esc %b/%b (expected/actual)",
                     results_seen, want.pos, got.pos, want.data, got.data,
                     want.pend, got.pend));
            end
         end
         if (hold_rsp) begin
            nxt = 1'b0;
         end else if (!idle_on) begin
            nxt = 1'b1;
         end else if (rsp_gap > 0) begin
            nxt = 1'b0;
            rsp_gap--;
         end else if ($urandom_range(0, 7) == 0) begin
            rsp_gap = $urandom_range(1, 3) - 1;
            nxt = 1'b0;
         end else begin
            nxt = 1'b1;
         end
         rsp_ch.ready <= nxt;
      end
   end

   // Hold off the receiver once so the engine backs up and stalls its input
   initial begin
      hold_rsp = 1'b0;
      wait (results_seen >= HOLD_AFTER);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      logic [ATTR_W-1:0] attr_val;
      int                phase_base;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.req_type   <= REQ_PUT;
      req_ch.char_code  <= '0;
      req_ch.cell_index <= '0;
      psel              <= 1'b0;
      penable           <= 1'b0;
      pwrite            <= 1'b0;
      paddr             <= '0;
      pwdata            <= '0;
      attr_shadow = ATTR_RESET;
      for (int i = 0; i < NCELLS; i++) screen_copy[i] = BLANK_RESET;
      cur_col   = '0;
      cur_row   = '0;
      esc_state = ESC_NONE;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (DIR_TAB[i]) send_req(DIR_TAB[i].rq, DIR_TAB[i].typed, DIR_TAB[i].rsp);

      for (int ph = 0; ph < PHASES; ph++) begin
         req_ch.valid <= 1'b0;
         wait_drained();
         if (ph > 0) begin
            if (ph == 1) attr_val = '0;
            else if (ph == 2) attr_val = '1;
            else attr_val = ATTR_W'($urandom_range(0, 255));
            set_attribute(attr_val);
         end
         // last phase runs flat out on both sides
         if (ph == PHASES - 1) idle_on = 1'b0;
         phase_base = items_sent;
         while (items_sent - phase_base < PHASE_ITEMS) feed_random_sequence();
      end
      req_ch.valid <= 1'b0;
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && result_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
